// ----- src/bfm_pkg.sv -----
// Package: shared types and constants of the five-channel block median filter.
package bfm_pkg;

  localparam int SAMPLES_PER_CHANNEL_DEF = 10;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_CH = 5;
  localparam int FIELD_BITS = 12;
  localparam logic [2:0] LAST_CH = 3'd4;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [FIELD_BITS-1:0] sample;
  } bfm_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] median_ch0;
    logic [FIELD_BITS-1:0] median_ch1;
    logic [FIELD_BITS-1:0] median_ch2;
    logic [FIELD_BITS-1:0] median_ch3;
    logic [FIELD_BITS-1:0] median_ch4;
  } bfm_out_t;

  typedef struct packed {
    logic start;
    logic ack;
  } sel_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sel_stat_t;

  typedef enum logic [2:0] {
    SEL_IDLE,
    SEL_CAND,
    SEL_LATCH,
    SEL_SCAN,
    SEL_DRAIN,
    SEL_EVAL,
    SEL_STORE,
    SEL_DONE
  } sel_state_t;

endpackage

// ----- src/bfm_store.sv -----
// Sample store: one write port and one registered read port.
module bfm_store #(
  parameter int DEPTH = 50,
  parameter int WIDTH = 12,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/bfm_select.sv -----
// Median engine: rank selection by counting over the store, channel by channel.
module bfm_select #(
  parameter int N = 10,
  parameter int SB = 12,
  parameter int ADDR_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bfm_pkg::sel_ctrl_t      ctrl,
  output bfm_pkg::sel_stat_t      stat,
  output logic [ADDR_W-1:0]       rd_addr,
  input  logic [SB-1:0]           rd_data,
  output logic [bfm_pkg::NUM_CH-1:0][SB-1:0] med
);
  import bfm_pkg::*;

  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
  localparam int CNT_W = $clog2(N + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);
  localparam logic [CNT_W-1:0] RANK_LO = CNT_W'(N / 2 - 1);
  localparam logic [CNT_W-1:0] RANK_HI = CNT_W'(N / 2);

  sel_state_t state_r, state_nxt;
  logic [2:0] ch_r, ch_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] lt_r, lt_nxt, le_r, le_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [SB-1:0] cand_r, lo_r, hi_r;
  logic [SB:0] sum;
  logic [ADDR_W-1:0] base;

  assign base = ADDR_W'(ch_r * N);
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEL_IDLE:  if (ctrl.start) state_nxt = SEL_CAND;
      SEL_CAND:  state_nxt = SEL_LATCH;
      SEL_LATCH: state_nxt = SEL_SCAN;
      SEL_SCAN:  if (j_r == LAST_IDX) state_nxt = SEL_DRAIN;
      SEL_DRAIN: state_nxt = SEL_EVAL;
      SEL_EVAL:  state_nxt = (i_r == LAST_IDX) ? SEL_STORE : SEL_CAND;
      SEL_STORE: state_nxt = (ch_r == LAST_CH) ? SEL_DONE : SEL_CAND;
      SEL_DONE:  if (ctrl.ack) state_nxt = SEL_IDLE;
      default:   state_nxt = SEL_IDLE;
    endcase
  end

  always_comb begin
    ch_nxt = ch_r;
    i_nxt = i_r;
    j_nxt = j_r;
    lt_nxt = lt_r;
    le_nxt = le_r;
    rd_vld_nxt = 1'b0;
    rd_addr = base + ADDR_W'(i_r);
    stat.busy = (state_r != SEL_IDLE);
    stat.done = (state_r == SEL_DONE);
    if (rd_vld_r) begin
      lt_nxt = lt_r + CNT_W'(rd_data < cand_r);
      le_nxt = le_r + CNT_W'(rd_data <= cand_r);
    end
    case (state_r)
      SEL_IDLE: begin
        ch_nxt = '0;
        i_nxt = '0;
      end
      SEL_LATCH: begin
        j_nxt = '0;
        lt_nxt = '0;
        le_nxt = '0;
      end
      SEL_SCAN: begin
        rd_addr = base + ADDR_W'(j_r);
        rd_vld_nxt = 1'b1;
        j_nxt = j_r + IDX_W'(1);
      end
      SEL_EVAL: begin
        i_nxt = i_r + IDX_W'(1);
      end
      SEL_STORE: begin
        i_nxt = '0;
        ch_nxt = ch_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    lt_r <= lt_nxt;
    le_r <= le_nxt;
    if (state_r == SEL_LATCH) cand_r <= rd_data;
    if (state_r == SEL_EVAL) begin
      if (lt_r <= RANK_LO && RANK_LO < le_r) lo_r <= cand_r;
      if (lt_r <= RANK_HI && RANK_HI < le_r) hi_r <= cand_r;
    end
    if (state_r == SEL_STORE) med[ch_r] <= sum[SB:1];
  end

  a_drain_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SEL_DRAIN |-> rd_vld_r)
    else $error("drain without pending read");

  a_counts_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SEL_EVAL |-> lt_r <= le_r && le_r != '0)
    else $error("rank counts inconsistent");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SEL_DONE && !ctrl.ack |=> state_r == SEL_DONE)
    else $error("result dropped before ack");

endmodule

// ----- src/five_channel_block_median.sv -----
// Top level: sample intake, block pointers, store, median engine and result register.
// Input beats are accepted while the median engine is idle. The beat that completes a
// block (channel 4 at the last position) starts the engine, which stalls the input
// while it runs, reading the store one sample at a time. The result enters the output
// register once that is free; until then the engine holds it and input stays stalled.
module five_channel_block_median #(
  parameter int SAMPLES_PER_CHANNEL = bfm_pkg::SAMPLES_PER_CHANNEL_DEF,
  parameter int SAMPLE_BITS = bfm_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfm_pkg::bfm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bfm_pkg::bfm_out_t out_data
);
  import bfm_pkg::*;

  localparam int N = SAMPLES_PER_CHANNEL;
  localparam int DEPTH = NUM_CH * N;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W = (N > 1) ? $clog2(N) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(N - 1);

  logic [2:0] ptr_r, ptr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic out_valid_r, out_valid_nxt;
  bfm_out_t out_r;
  logic in_acc, wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] med;
  sel_ctrl_t ctrl;
  sel_stat_t stat;

  assign in_stall = stat.busy;
  assign in_acc = in_valid && !in_stall;
  assign wr_en = in_acc && in_data.command == CMD_STORE;
  assign wr_addr = ADDR_W'(ptr_r * N) + ADDR_W'(pos_r);
  assign ctrl.start = wr_en && ptr_r == LAST_CH && pos_r == LAST_POS;
  assign ctrl.ack = stat.done && !out_valid_r;

  always_comb begin
    ptr_nxt = ptr_r;
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_data.command == CMD_RESTART) begin
        ptr_nxt = '0;
        pos_nxt = '0;
      end else if (ptr_r == LAST_CH) begin
        ptr_nxt = '0;
        pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + POS_W'(1);
      end else begin
        ptr_nxt = ptr_r + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ctrl.ack) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      pos_r <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ack) begin
      out_r.median_ch0 <= FIELD_BITS'(med[0]);
      out_r.median_ch1 <= FIELD_BITS'(med[1]);
      out_r.median_ch2 <= FIELD_BITS'(med[2]);
      out_r.median_ch3 <= FIELD_BITS'(med[3]);
      out_r.median_ch4 <= FIELD_BITS'(med[4]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  bfm_store #(.DEPTH(DEPTH), .WIDTH(SAMPLE_BITS), .ADDR_W(ADDR_W)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (SAMPLE_BITS'(in_data.sample)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfm_select #(.N(N), .SB(SAMPLE_BITS), .ADDR_W(ADDR_W)) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .stat    (stat),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .med     (med)
  );

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !stat.busy)
    else $error("engine started while busy");

  a_ack_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ack |=> out_valid_r)
    else $error("finished result not presented");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.command == CMD_RESTART |=> ptr_r == '0 && pos_r == '0)
    else $error("restart did not clear pointers");

endmodule

// ----- test/tb_five_channel_block_median.sv -----
// Testbench: five-channel block median filter checked beat by beat against a built-in model.
module tb_five_channel_block_median;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int N_SAMP = SAMPLES_PER_CHANNEL_DEF;
  localparam int N_RANDOM = 1550;
  localparam int IDLE_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 700;

  typedef struct packed {
    logic                  command;
    logic [FIELD_BITS-1:0] sample;
  } row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  bfm_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  bfm_out_t out_data;

  logic [FIELD_BITS-1:0] blk_store [NUM_CH][N_SAMP];
  int unsigned           cur_ch;
  int unsigned           cur_pos;
  bfm_out_t              median_q [$];
  int                    errors;
  int                    idle_cycles;
  bit                    hold_req;

  five_channel_block_median u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [FIELD_BITS-1:0] block_median(int unsigned ch);
    logic [FIELD_BITS-1:0] srt [N_SAMP];
    logic [FIELD_BITS-1:0] t;
    logic [FIELD_BITS:0]   sum;
    int                    j;
    for (int i = 0; i < N_SAMP; i++) begin
      srt[i] = blk_store[ch][i];
    end
    for (int i = 1; i < N_SAMP; i++) begin
      t = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > t) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = t;
    end
    sum = srt[N_SAMP/2 - 1] + srt[N_SAMP/2];
    return sum[FIELD_BITS:1];
  endfunction

  task automatic advance_medians(bfm_in_t d);
    bfm_out_t r;
    if (d.command == CMD_RESTART) begin
      cur_ch = 0;
      cur_pos = 0;
    end else begin
      blk_store[cur_ch][cur_pos] = d.sample;
      if (cur_ch == LAST_CH) begin
        cur_ch = 0;
        cur_pos++;
      end else begin
        cur_ch++;
      end
      if (cur_pos == N_SAMP) begin
        cur_pos = 0;
        r.median_ch0 = block_median(0);
        r.median_ch1 = block_median(1);
        r.median_ch2 = block_median(2);
        r.median_ch3 = block_median(3);
        r.median_ch4 = block_median(4);
        median_q.push_back(r);
      end
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return FIELD_BITS'($urandom_range(8) + 2040);
      default: return FIELD_BITS'($urandom());
    endcase
  endfunction

  task automatic send_beat(bfm_in_t d, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_medians(d);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[five_channel_block_median] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bfm_out_t exp_r;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          $error("unexpected result beat %h", out_data);
          errors++;
        end else begin
          exp_r = median_q.pop_front();
          if (out_data.median_ch0 !== exp_r.median_ch0) begin
            $error("median_ch0 exp %0d got %0d", exp_r.median_ch0, out_data.median_ch0);
            errors++;
          end
          if (out_data.median_ch1 !== exp_r.median_ch1) begin
            $error("median_ch1 exp %0d got %0d", exp_r.median_ch1, out_data.median_ch1);
            errors++;
          end
          if (out_data.median_ch2 !== exp_r.median_ch2) begin
            $error("median_ch2 exp %0d got %0d", exp_r.median_ch2, out_data.median_ch2);
            errors++;
          end
          if (out_data.median_ch3 !== exp_r.median_ch3) begin
            $error("median_ch3 exp %0d got %0d", exp_r.median_ch3, out_data.median_ch3);
            errors++;
          end
          if (out_data.median_ch4 !== exp_r.median_ch4) begin
            $error("median_ch4 exp %0d got %0d", exp_r.median_ch4, out_data.median_ch4);
            errors++;
          end
        end
      end
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(99) < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(60, 10)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < 70) ? 1'b0 : 1'b1;
      end
    end
  end

  row_t directed [] = '{
    '{CMD_STORE, 12'h000}, '{CMD_STORE, 12'hFFF}, '{CMD_STORE, 12'h800},
    '{CMD_STORE, 12'h7FF}, '{CMD_STORE, 12'h001}, '{CMD_STORE, 12'hFFE},
    '{CMD_RESTART, 12'hFFF}, '{CMD_STORE, 12'hAAA}, '{CMD_STORE, 12'h555},
    '{CMD_RESTART, 12'h000}, '{CMD_RESTART, 12'h123}, '{CMD_STORE, 12'hFFF},
    '{CMD_STORE, 12'hFFF}, '{CMD_STORE, 12'hFFF}, '{CMD_STORE, 12'hFFF},
    '{CMD_STORE, 12'hFFF}, '{CMD_STORE, 12'h000}, '{CMD_STORE, 12'h000},
    '{CMD_STORE, 12'h000}, '{CMD_STORE, 12'h000}, '{CMD_STORE, 12'h000},
    '{CMD_STORE, 12'hF0F}, '{CMD_RESTART, 12'hABC}
  };

  initial begin
    bfm_in_t d;
    int      n;
    errors = 0;
    hold_req = 1'b0;
    cur_ch = 0;
    cur_pos = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      d.command = directed[i].command;
      d.sample = directed[i].sample;
      send_beat(d, gap_len());
    end
    n = 0;
    while (n < N_RANDOM) begin
      if (n == 400) hold_req = 1'b1;
      if (n == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (median_q.size() != 0) @(posedge clk);
      end
      d.command = ($urandom_range(199) == 0) ? CMD_RESTART : CMD_STORE;
      d.sample = (n < 600) ? rand_sample() : FIELD_BITS'($urandom());
      send_beat(d, (n % 300 < 60) ? 0 : gap_len());
      n++;
    end
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[five_channel_block_median] OK");
    end else begin
      $display("[five_channel_block_median] ERROR");
    end
    $finish;
  end
endmodule

// ----- five_channel_block_median.f -----
src/bfm_pkg.sv
src/bfm_store.sv
src/bfm_select.sv
src/five_channel_block_median.sv
test/tb_five_channel_block_median.sv
